[rtl/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
// No dependencies; included by the files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HFD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HFD_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HFD_ASSERT(lbl, clk, rst, prop, msg)
`define HFD_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

[rtl/hfdec_pkg.sv]
// Types and codes for the serialised-tree Huffman decoder.
// No dependencies.
package hfdec_pkg;

  typedef struct packed {
    logic in_bit;
    logic stream_start;
  } hfdec_in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic [1:0] out_status;
  } hfdec_out_t;

  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [15:0] END_SYMBOL_RESET = 16'd1000;

endpackage

[rtl/hfdec_ram.sv]
// Single-port-write, single-port-read RAM with registered read data.
// A write to the address being read is forwarded to the read data.
module hfdec_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 27
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/hfdec_out_skid.sv]
// Output register with one skid entry for the result channel.
// Depends on hfdec_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hfdec_out_skid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  hfdec_pkg::hfdec_out_t  res,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output hfdec_pkg::hfdec_out_t  out_data
);
  import hfdec_pkg::*;

  logic       skid_valid;
  hfdec_out_t skid_data;
  logic       load_main;
  logic       load_skid;

  // main register takes the skid entry first, then a fresh result
  assign load_main = skid_valid ? !out_stall : (res_valid && (!out_valid || !out_stall));
  assign load_skid = !skid_valid && res_valid && out_valid && out_stall;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (!out_stall) begin
          skid_valid <= 1'b0;
        end
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end
      if (load_main) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (load_skid) begin
      skid_data <= res;
    end
  end

  `HFD_ASSERT(a_no_res_when_full, clk, rst, skid_valid |-> !res_valid, "result offered while skid full")
  `HFD_ASSERT(a_skid_implies_out, clk, rst, skid_valid |-> out_valid, "skid entry without main entry")
  `HFD_ASSERT(a_skid_drains, clk, rst, (skid_valid && !out_stall) |=> (out_valid && !skid_valid), "skid entry lost on transfer")

endmodule

[rtl/huffman_tree_load_decoder_top.sv]
// Huffman decoder with a serialised pre-order code tree, one bit per transfer.
// Depends on hfdec_pkg, hfdec_ram, hfdec_out_skid and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one stream bit per
//   transfer, MSB first: the tree header, then the coded content. A set
//   stream_start clears the stream state and its bit is the first of the new
//   stream. Output channel (out_valid / out_stall / out_data) carries a byte
//   (status 0), an end marker (status 1) or a tree error (status 2).
//   cfg_we / cfg_wdata write end_symbol; write it only while idle.
// Timing:
//   One bit is taken every cycle while in_stall is low, both while loading and while decoding.
//   A result is registered into the output register, or into the skid entry while out_stall holds out_valid.
//   Each child record holds the child's index, leaf flag and symbol, so one
//   read of the left/right RAMs per bit decides the step; the next node's
//   records are read at the same edge the bit is taken.
//   On an output stall one result is held in the skid entry; in_stall rises
//   only once that entry is occupied.
// Reset:
//   Synchronous rst clears control state; end_symbol returns to 1000. The
//   node and stack RAMs are not cleared and need no clearing pass.
`include "assert_macros.svh"
module huffman_tree_load_decoder_top #(
  parameter int NODE_DEPTH  = 1024,
  parameter int STACK_DEPTH = 512,
  parameter int SYMBOL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hfdec_pkg::hfdec_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hfdec_pkg::hfdec_out_t out_data,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata
);
  import hfdec_pkg::*;

  localparam int NW  = $clog2(NODE_DEPTH);
  localparam int CW  = $clog2(NODE_DEPTH + 1);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SB  = SYMBOL_BITS;
  localparam int BW  = $clog2(SYMBOL_BITS + 1);
  localparam int RW  = NW + 1 + SB;

  localparam logic [1:0] PH_LOAD   = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic [1:0]    phase, phase_next;
  logic [CW-1:0] nfn, nfn_next;
  logic [SPW-1:0] sp, sp_next;
  logic [NW-1:0] attach_parent, attach_parent_next;
  logic          attach_right, attach_right_next;
  logic [SB-1:0] sym_shift, sym_shift_next;
  logic [BW-1:0] sym_left, sym_left_next;
  logic [NW-1:0] walk, walk_next;
  logic [15:0]   end_symbol;

  logic          acc;
  logic [1:0]    phase_e;
  logic [CW-1:0] nfn_e;
  logic [SPW-1:0] sp_e;
  logic [NW-1:0] ap_e;
  logic          ar_e;
  logic [BW-1:0] left_e;
  logic [NW-1:0] walk_e;
  logic [CW-1:0] nfn_last;
  logic [SPW-1:0] sp_m1;

  logic          node_we;
  logic          node_side;
  logic [NW-1:0] node_waddr;
  logic [RW-1:0] node_wdata;
  logic [RW-1:0] left_rdata, right_rdata, rec;
  logic [NW-1:0] rec_idx;
  logic          rec_leaf;
  logic [SB-1:0] rec_sym;

  logic          stk_we;
  logic [SW-1:0] stk_raddr;
  logic [NW-1:0] stk_top;

  logic          res_valid;
  hfdec_out_t    res;
  logic          skid_full;

  assign in_stall = skid_full;
  assign acc      = in_valid && !in_stall;

  // stream_start clears the stream state before the bit is applied
  assign phase_e = in_data.stream_start ? PH_LOAD : phase;
  assign nfn_e   = in_data.stream_start ? '0 : nfn;
  assign sp_e    = in_data.stream_start ? '0 : sp;
  assign ap_e    = in_data.stream_start ? '0 : attach_parent;
  assign ar_e    = in_data.stream_start ? 1'b0 : attach_right;
  assign left_e  = in_data.stream_start ? '0 : sym_left;
  assign walk_e  = in_data.stream_start ? '0 : walk;
  assign nfn_last = nfn_e - CW'(1);

  assign rec      = in_data.in_bit ? right_rdata : left_rdata;
  assign rec_idx  = rec[RW-1 -: NW];
  assign rec_leaf = rec[SB];
  assign rec_sym  = rec[SB-1:0];

  always_comb begin
    phase_next         = phase;
    nfn_next           = nfn;
    sp_next            = sp;
    attach_parent_next = attach_parent;
    attach_right_next  = attach_right;
    sym_shift_next     = sym_shift;
    sym_left_next      = sym_left;
    walk_next          = walk;
    node_we            = 1'b0;
    node_side          = ar_e;
    node_waddr         = ap_e;
    node_wdata         = '0;
    stk_we             = 1'b0;
    res_valid          = 1'b0;
    res                = '0;
    if (acc) begin
      phase_next         = phase_e;
      nfn_next           = nfn_e;
      sp_next            = sp_e;
      attach_parent_next = ap_e;
      attach_right_next  = ar_e;
      sym_left_next      = left_e;
      walk_next          = walk_e;
      unique case (phase_e)
        PH_LOAD: begin
          if (left_e != '0) begin
            sym_shift_next = {sym_shift[SB-2:0], in_data.in_bit};
            sym_left_next  = left_e - BW'(1);
            if (left_e == BW'(1)) begin
              if (nfn_e == CW'(1)) begin
                // tree is a lone leaf
                phase_next     = PH_DONE;
                res_valid      = 1'b1;
                res.out_status = ST_END;
              end else begin
                // leaf complete: fill in its symbol in the parent's record
                node_we    = 1'b1;
                node_wdata = {nfn_last[NW-1:0], 1'b1, sym_shift[SB-2:0], in_data.in_bit};
                if (sp_e == '0) begin
                  phase_next = PH_DECODE;
                  walk_next  = '0;
                end else begin
                  sp_next            = sp_e - SPW'(1);
                  attach_parent_next = stk_top;
                  attach_right_next  = 1'b1;
                end
              end
            end
          end else if (nfn_e >= CW'(NODE_DEPTH)) begin
            phase_next     = PH_DONE;
            res_valid      = 1'b1;
            res.out_status = ST_ERROR;
          end else begin
            nfn_next   = nfn_e + CW'(1);
            node_we    = (nfn_e != '0);
            node_wdata = {nfn_e[NW-1:0], in_data.in_bit, {SB{1'b0}}};
            if (in_data.in_bit) begin
              sym_shift_next = '0;
              sym_left_next  = BW'(SYMBOL_BITS);
            end else if (sp_e >= SPW'(STACK_DEPTH)) begin
              phase_next     = PH_DONE;
              res_valid      = 1'b1;
              res.out_status = ST_ERROR;
            end else begin
              stk_we             = 1'b1;
              sp_next            = sp_e + SPW'(1);
              attach_parent_next = nfn_e[NW-1:0];
              attach_right_next  = 1'b0;
            end
          end
        end
        PH_DECODE: begin
          if (rec_leaf) begin
            walk_next = '0;
            res_valid = 1'b1;
            if (16'(rec_sym) == end_symbol) begin
              phase_next     = PH_DONE;
              res.out_status = ST_END;
            end else begin
              res.out_symbol = rec_sym[7:0];
              res.out_status = ST_BYTE;
            end
          end else begin
            walk_next = rec_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // keep the stack RAM output on the current top entry
  assign sp_m1     = sp_next - SPW'(1);
  assign stk_raddr = (sp_next == '0) ? '0 : sp_m1[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LOAD;
      nfn           <= '0;
      sp            <= '0;
      attach_parent <= '0;
      attach_right  <= 1'b0;
      sym_left      <= '0;
      walk          <= '0;
      end_symbol    <= END_SYMBOL_RESET;
    end else begin
      phase         <= phase_next;
      nfn           <= nfn_next;
      sp            <= sp_next;
      attach_parent <= attach_parent_next;
      attach_right  <= attach_right_next;
      sym_left      <= sym_left_next;
      walk          <= walk_next;
      if (cfg_we) begin
        end_symbol <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_shift <= sym_shift_next;
  end

  hfdec_ram #(.DEPTH(NODE_DEPTH), .WIDTH(RW)) u_left_ram (
    .clk   (clk),
    .we    (node_we && !node_side),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (walk_next),
    .rdata (left_rdata)
  );

  hfdec_ram #(.DEPTH(NODE_DEPTH), .WIDTH(RW)) u_right_ram (
    .clk   (clk),
    .we    (node_we && node_side),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (walk_next),
    .rdata (right_rdata)
  );

  hfdec_ram #(.DEPTH(STACK_DEPTH), .WIDTH(NW)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp_e[SW-1:0]),
    .wdata (nfn_e[NW-1:0]),
    .raddr (stk_raddr),
    .rdata (stk_top)
  );

  hfdec_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `HFD_ASSERT(a_decode_clean, clk, rst, (phase == PH_DECODE) |-> (sp == '0 && sym_left == '0), "decoding with pending tree state")
  `HFD_ASSERT(a_stack_bound, clk, rst, (sp <= SPW'(STACK_DEPTH)) && (nfn <= CW'(NODE_DEPTH)), "stack or node count out of range")
  `HFD_ASSERT(a_finish_done, clk, rst, (acc && res_valid && res.out_status != ST_BYTE) |=> (phase == PH_DONE), "end or error result without finishing")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for huffman_tree_load_decoder_top: drives tree headers and content,
// compares every output transfer with a cycle-free shadow decoder. Needs hfdec_pkg and the RTL.
module tb_top;
  import hfdec_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int STACK_SLOTS = 512;
  localparam int SYM_WIDTH   = 16;
  localparam int CYCLE_LIMIT = 250000;
  localparam int NUM_PROBES  = 42;
  localparam int PHASE_ITEMS = 230;

  typedef enum logic [1:0] {LOADING, DECODING, FINISHED} stream_phase_e;

  typedef struct packed {
    logic       in_bit;
    logic       start;
    logic [9:0] count;
    logic       typed;
    logic [7:0] want_sym;
    logic [1:0] want_status;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  hfdec_in_t   in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  hfdec_out_t  out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // shadow copy of the decoder
  stream_phase_e shadow_phase = LOADING;
  bit [9:0]    tree_left  [TABLE_DEPTH];
  bit [9:0]    tree_right [TABLE_DEPTH];
  bit          tree_leaf  [TABLE_DEPTH];
  bit [15:0]   tree_sym   [TABLE_DEPTH];
  bit [9:0]    pending    [STACK_SLOTS];
  int unsigned nodes_used = 0;
  int unsigned pending_cnt = 0;
  logic [9:0]  hook_parent = '0;
  logic        hook_right = 1'b0;
  logic [15:0] sym_acc = '0;
  int unsigned sym_left = 0;
  logic [9:0]  walk_at = '0;
  logic [15:0] end_sym = END_SYMBOL_RESET;

  hfdec_out_t  awaited [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned random_items = 0;
  bit          steady = 1'b0;

  // header-only items have no result, so stat checks are by predictor except these
  probe_row_t probes [0:NUM_PROBES-1] = '{
    // single-leaf tree ends at once
    '{1'b1, 1'b1, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd15,  1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b1, 8'h00, ST_END},
    // finished: ignored until a new stream
    '{1'b1, 1'b0, 10'd2,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    // root with leaves 0xffff and 1000
    '{1'b0, 1'b1, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd16,  1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd6,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd5,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd3,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd1,   1'b1, 8'hFF, ST_BYTE},
    '{1'b0, 1'b0, 10'd1,   1'b1, 8'hFF, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b1, 8'h00, ST_END},
    // left-deep tree: 00 -> 0x0000, 01 -> 0x00ff, 1 -> end
    '{1'b0, 1'b1, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd16,  1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd8,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd8,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd6,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd5,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd3,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd1,   1'b1, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b1, 8'hFF, ST_BYTE},
    '{1'b1, 1'b0, 10'd1,   1'b1, 8'h00, ST_END},
    // pending stack overflows on the 513th internal node
    '{1'b0, 1'b1, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd512, 1'b1, 8'h00, ST_ERROR},
    '{1'b1, 1'b0, 10'd1,   1'b0, 8'h00, ST_BYTE},
    // header cut short by a new stream
    '{1'b0, 1'b1, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b0, 10'd4,   1'b0, 8'h00, ST_BYTE},
    '{1'b1, 1'b1, 10'd1,   1'b0, 8'h00, ST_BYTE},
    '{1'b0, 1'b0, 10'd16,  1'b1, 8'h00, ST_END}
  };

  huffman_tree_load_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic bit shadow_step(input hfdec_in_t item, output hfdec_out_t res);
    int unsigned n;
    logic [9:0]  child;
    res = '0;
    if (item.stream_start) begin
      shadow_phase = LOADING;
      nodes_used   = 0;
      pending_cnt  = 0;
      hook_parent  = '0;
      hook_right   = 1'b0;
      sym_acc      = '0;
      sym_left     = 0;
      walk_at      = '0;
    end
    case (shadow_phase)
      LOADING: begin
        if (sym_left != 0) begin
          sym_acc = {sym_acc[14:0], item.in_bit};
          sym_left--;
          if (sym_left != 0) return 1'b0;
          n = (nodes_used - 1) % TABLE_DEPTH;
          tree_sym[n] = sym_acc;
          if (pending_cnt == 0) begin
            shadow_phase = DECODING;
            walk_at = '0;
            // a lone leaf is the whole content
            if (n == 0) begin
              shadow_phase = FINISHED;
              res.out_status = ST_END;
              return 1'b1;
            end
            return 1'b0;
          end
          pending_cnt--;
          hook_parent = pending[pending_cnt];
          hook_right = 1'b1;
          return 1'b0;
        end
        if (nodes_used >= TABLE_DEPTH) begin
          shadow_phase = FINISHED;
          res.out_status = ST_ERROR;
          return 1'b1;
        end
        n = nodes_used;
        nodes_used++;
        if (n != 0) begin
          if (hook_right) tree_right[hook_parent] = 10'(n);
          else tree_left[hook_parent] = 10'(n);
        end
        tree_leaf[n] = item.in_bit;
        if (item.in_bit) begin
          sym_acc = '0;
          sym_left = SYM_WIDTH;
          return 1'b0;
        end
        if (pending_cnt >= STACK_SLOTS) begin
          shadow_phase = FINISHED;
          res.out_status = ST_ERROR;
          return 1'b1;
        end
        pending[pending_cnt] = 10'(n);
        pending_cnt++;
        hook_parent = 10'(n);
        hook_right = 1'b0;
        return 1'b0;
      end
      DECODING: begin
        child = item.in_bit ? tree_right[walk_at] : tree_left[walk_at];
        if (!tree_leaf[child]) begin
          walk_at = child;
          return 1'b0;
        end
        walk_at = '0;
        if (tree_sym[child] == end_sym) begin
          shadow_phase = FINISHED;
          res.out_status = ST_END;
          return 1'b1;
        end
        res.out_symbol = tree_sym[child][7:0];
        res.out_status = ST_BYTE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // one input transfer; a typed result overrides the shadow's prediction
  task automatic send_bit(input logic b, input logic start, input bit typed,
                          input hfdec_out_t typed_res);
    hfdec_in_t  item;
    hfdec_out_t got;
    bit         has;
    item.in_bit = b;
    item.stream_start = start;
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    has = shadow_step(item, got);
    if (typed) awaited.push_back(typed_res);
    else if (has) awaited.push_back(got);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed_bit(input logic b, input logic start);
    bit ignored;
    ignored = !start && shadow_phase == FINISHED;
    send_bit(b, start, 1'b0, '0);
    if (!ignored) random_items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic play_stream();
    bit          hdr [$];
    int unsigned kind, leaves, internals_left, slots, leaf_no, budget, cut, pick;
    int          end_leaf;
    logic [15:0] sym;
    kind = $urandom_range(99);
    if (kind < 8) begin
      feed_bit(1'($urandom_range(1)), 1'b1);
      repeat ($urandom_range(40, 4)) feed_bit(1'($urandom_range(1)), 1'b0);
      return;
    end
    if (kind < 12) begin
      repeat ($urandom_range(20, 2)) feed_bit(1'($urandom_range(1)), 1'b0);
      return;
    end
    pick = $urandom_range(19);
    if (pick < 2) leaves = 1;
    else if (pick == 2) leaves = $urandom_range(60, 20);
    else leaves = $urandom_range(8, 2);
    internals_left = leaves - 1;
    slots = 1;
    leaf_no = 0;
    end_leaf = ($urandom_range(99) < 85) ? int'($urandom_range(leaves - 1)) : -1;
    // pre-order shape: an internal node takes one open slot and opens two
    while (slots > 0) begin
      if (internals_left > 0 && (slots == 1 || $urandom_range(1))) begin
        hdr.push_back(1'b0);
        internals_left--;
        slots++;
      end else begin
        pick = $urandom_range(9);
        if (int'(leaf_no) == end_leaf) sym = end_sym;
        else if (pick == 0) sym = 16'h0000;
        else if (pick == 1) sym = 16'hFFFF;
        else sym = 16'($urandom);
        hdr.push_back(1'b1);
        for (int k = SYM_WIDTH - 1; k >= 0; k--) hdr.push_back(sym[k]);
        leaf_no++;
        slots--;
      end
    end
    cut = (kind < 20) ? $urandom_range(hdr.size() - 1, 1) : hdr.size();
    foreach (hdr[i]) if (i < cut) feed_bit(hdr[i], i == 0);
    if (cut < hdr.size()) return;
    budget = $urandom_range(80, 8);
    while (shadow_phase == DECODING && budget > 0) begin
      feed_bit(1'($urandom_range(1)), 1'b0);
      budget--;
    end
    if (shadow_phase == FINISHED && $urandom_range(3) == 0)
      repeat ($urandom_range(3, 1)) feed_bit(1'($urandom_range(1)), 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !steady && $urandom_range(99) < 19;
  end

  always @(posedge clk) begin : check_results
    hfdec_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        errors++;
        if (errors < 40)
          $display("%0t: unexpected transfer symbol %h status %0d", $time,
                   out_data.out_symbol, out_data.out_status);
      end else begin
        want = awaited.pop_front();
        if (out_data.out_symbol !== want.out_symbol) begin
          errors++;
          if (errors < 40)
            $display("%0t: out_symbol expected %h actual %h", $time,
                     want.out_symbol, out_data.out_symbol);
        end
        if (out_data.out_status !== want.out_status) begin
          errors++;
          if (errors < 40)
            $display("%0t: out_status expected %0d actual %0d", $time,
                     want.out_status, out_data.out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("huffman_tree_load_decoder_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] end_values [5];
    probe_row_t  row;
    hfdec_out_t  typed_res;
    end_values = '{16'h0000, 16'hFFFF, 16'($urandom), END_SYMBOL_RESET, 16'($urandom)};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[r]) begin
      row = probes[r];
      typed_res.out_symbol = row.want_sym;
      typed_res.out_status = row.want_status;
      for (int k = 1; k <= int'(row.count); k++)
        send_bit(row.in_bit, row.start, row.typed && k == int'(row.count), typed_res);
    end

    // node table fills: the root stays pending so the tree never closes
    send_bit(1'b0, 1'b1, 1'b0, '0);
    repeat (TABLE_DEPTH / 2 - 1) begin
      send_bit(1'b0, 1'b0, 1'b0, '0);
      send_bit(1'b1, 1'b0, 1'b0, '0);
      repeat (SYM_WIDTH) send_bit(1'($urandom_range(1)), 1'b0, 1'b0, '0);
    end
    send_bit(1'b1, 1'b0, 1'b0, '0);
    repeat (SYM_WIDTH) send_bit(1'($urandom_range(1)), 1'b0, 1'b0, '0);
    typed_res.out_symbol = 8'h00;
    typed_res.out_status = ST_ERROR;
    send_bit(1'($urandom_range(1)), 1'b0, 1'b1, typed_res);

    for (int p = 0; p < 5; p++) begin
      settle();
      cfg_we    <= 1'b1;
      cfg_wdata <= end_values[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      end_sym = end_values[p];
      steady = (p == 2);
      while (random_items < (p + 1) * PHASE_ITEMS) play_stream();
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("huffman_tree_load_decoder_top regression: pass");
    else $display("huffman_tree_load_decoder_top regression: fail");
    $finish;
  end

endmodule
